// ===== hdl/trww_pkg.sv =====
// package for the transfer rate weighted window: sizes, payload types, states
`default_nettype none
package trww_pkg;

  localparam int WINDOW_DEPTH = 30;
  localparam int MS_PER_SECOND = 1000;

  localparam int TOTAL_W   = 48;
  localparam int ELAPSED_W = 16;
  localparam int RATE_W    = 40;
  localparam int HELD_W    = 5;

  localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int WDIV_W  = $clog2(WINDOW_DEPTH * (WINDOW_DEPTH + 1) / 2 + 1);
  localparam int WSUM_W  = RATE_W + WDIV_W;
  localparam int PROD_W  = RATE_W + FILL_W;

  // delta * 1000 stays below 2^58
  localparam int DIVIDEND_W = TOTAL_W + 10;
  localparam int DIVISOR_W  = ELAPSED_W;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  typedef struct packed {
    logic [TOTAL_W-1:0]   total_bytes;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [RATE_W-1:0] average_rate;
    logic [RATE_W-1:0] instant_rate;
    logic [HELD_W-1:0] samples_held;
  } out_item_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_RATE_START,
    ST_RATE_WAIT,
    ST_WRITE,
    ST_WALK,
    ST_AVG_START,
    ST_AVG_WAIT,
    ST_OUT
  } trww_state_t;

endpackage
`default_nettype wire

// ===== hdl/trww_divider.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module trww_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire trww_pkg::div_req_t req,
  output trww_pkg::div_rsp_t      rsp
);
  import trww_pkg::*;

  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dsr_r, dsr_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign fits  = (trial >= {1'b0, dsr_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt = req.dividend;
      rem_nxt = '0;
      dsr_nxt = req.divisor;
      cnt_nxt = DIV_CNT_W'(DIVIDEND_W);
    end else if (cnt_r != '0) begin
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      rem_nxt = fits ? DIVISOR_W'(trial - {1'b0, dsr_r}) : DIVISOR_W'(trial);
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      done_nxt = (cnt_r == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

// ===== hdl/transfer_rate_weighted_window_core.sv =====
// top level of the transfer rate meter with a linearly weighted window
//
// channel  direction  handshake          payload
// in_      input      in_valid/in_stall  in_item_t  (total_bytes, elapsed_ms)
// out_     output     out_valid/out_stall out_item_t (average_rate, instant_rate,
//                                                    samples_held)
// cfg_     input      cfg_valid/cfg_ready cfg_data   (enable)
//
// a tick that produces a result makes two passes through the bit-serial divider and
// one walk over the window memory (up to 30 samples), one sample a cycle.
// a disabled or zero-elapsed tick is accepted and leaves no result.
// reset is synchronous, active low; the window memory holds no reset value.
// the next tick is accepted while a result still waits in the output register;
// the block holds in its last step until that register is free.
`default_nettype none
module transfer_rate_weighted_window_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire trww_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output trww_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_data
);
  import trww_pkg::*;

  trww_state_t state_r, state_nxt;

  logic                  enable_r;
  logic [TOTAL_W-1:0]    prev_total_r;
  logic [TOTAL_W-1:0]    delta_r;
  logic [ELAPSED_W-1:0]  elapsed_r;
  logic [DIVIDEND_W-1:0] acc_r;
  logic [RATE_W-1:0]     rate_r;
  logic [RATE_W-1:0]     avg_r;
  logic [SLOT_W-1:0]     newest_r;
  logic [FILL_W-1:0]     fill_r;
  logic [SLOT_W-1:0]     ptr_r;
  logic [FILL_W-1:0]     w_r;
  logic [FILL_W-1:0]     w1_r;
  logic                  v1_r, v2_r;
  logic [RATE_W-1:0]     rd_r;
  logic [PROD_W-1:0]     prod_r;
  logic [WSUM_W-1:0]     wsum_r;
  logic [WDIV_W-1:0]     wdiv_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  logic [RATE_W-1:0]     mem [WINDOW_DEPTH];

  logic                  accept;
  logic                  measure;
  logic                  out_free;
  logic                  out_load;
  logic [SLOT_W-1:0]     slot_next;
  logic [FILL_W-1:0]     fill_next;
  logic [RATE_W-1:0]     rate_sat;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign measure   = enable_r && (in_data.elapsed_ms != '0);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == ST_OUT) && out_free;

  assign slot_next = (newest_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : newest_r + SLOT_W'(1);
  assign fill_next = (fill_r < FILL_W'(WINDOW_DEPTH)) ? fill_r + FILL_W'(1) : fill_r;
  assign rate_sat  = (|div_rsp.quotient[DIVIDEND_W-1:RATE_W]) ? '1
                                                               : div_rsp.quotient[RATE_W-1:0];

  trww_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.dividend = acc_r;
    div_req.divisor  = elapsed_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && measure) begin
          state_nxt = ST_MUL_A;
        end
      end
      ST_MUL_A: state_nxt = ST_MUL_B;
      ST_MUL_B: state_nxt = ST_RATE_START;
      ST_RATE_START: begin
        div_req.start = 1'b1;
        state_nxt     = ST_RATE_WAIT;
      end
      ST_RATE_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: state_nxt = ST_WALK;
      ST_WALK: begin
        if (w_r == '0 && !v1_r && !v2_r) begin
          state_nxt = ST_AVG_START;
        end
      end
      ST_AVG_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIVIDEND_W'(wsum_r);
        div_req.divisor  = DIVISOR_W'(wdiv_r);
        state_nxt        = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      prev_total_r <= '0;
      newest_r     <= '0;
      fill_r       <= '0;
      w_r          <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        enable_r <= cfg_data;
      end
      if (accept && measure) begin
        prev_total_r <= in_data.total_bytes;
      end
      if (state_r == ST_WRITE) begin
        newest_r <= slot_next;
        fill_r   <= fill_next;
        w_r      <= fill_next;
      end else if (state_r == ST_WALK && w_r != '0) begin
        w_r <= w_r - FILL_W'(1);
      end
      v1_r <= (state_r == ST_WALK) && (w_r != '0);
      v2_r <= v1_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      delta_r   <= (in_data.total_bytes > prev_total_r) ? in_data.total_bytes - prev_total_r
                                                        : '0;
      elapsed_r <= in_data.elapsed_ms;
    end
    // times 1000 as (x << 10) - (x << 4) - (x << 3)
    if (state_r == ST_MUL_A) begin
      acc_r <= {delta_r, 10'b0} - {6'b0, delta_r, 4'b0};
    end
    if (state_r == ST_MUL_B) begin
      acc_r <= acc_r - {7'b0, delta_r, 3'b0};
    end
    if (state_r == ST_RATE_WAIT && div_rsp.done) begin
      rate_r <= rate_sat;
    end
    if (state_r == ST_WRITE) begin
      ptr_r  <= slot_next;
      wsum_r <= '0;
      wdiv_r <= '0;
    end else if (state_r == ST_WALK) begin
      if (w_r != '0) begin
        ptr_r <= (ptr_r == '0) ? SLOT_W'(WINDOW_DEPTH - 1) : ptr_r - SLOT_W'(1);
      end
      if (v1_r) begin
        wdiv_r <= wdiv_r + WDIV_W'(w1_r);
      end
      if (v2_r) begin
        wsum_r <= wsum_r + WSUM_W'(prod_r);
      end
    end
    w1_r   <= w_r;
    prod_r <= PROD_W'(rd_r) * PROD_W'(w1_r);
    if (state_r == ST_AVG_WAIT && div_rsp.done) begin
      avg_r <= div_rsp.quotient[RATE_W-1:0];
    end
    if (out_load) begin
      out_data_r.average_rate <= avg_r;
      out_data_r.instant_rate <= rate_r;
      out_data_r.samples_held <= HELD_W'(fill_r);
    end
  end

  // window memory, newest sample written before the walk reads back
  always_ff @(posedge clk) begin
    if (state_r == ST_WRITE) begin
      mem[slot_next] <= rate_r;
    end
    rd_r <= mem[ptr_r];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== bench/transfer_rate_weighted_window_core_test.sv =====
// testbench for the transfer rate meter core: directed table, random ticks, scoreboard
`timescale 1ns / 1ps
module transfer_rate_weighted_window_core_test;
  import trww_pkg::*;

  localparam int ITEM_TARGET  = 1050;
  localparam int DRAIN_CYCLES = 200;
  localparam int IDLE_LIMIT   = 4000;
  localparam int MAX_PRINTS   = 50;
  localparam logic [RATE_W-1:0]  RATE_MAX  = {RATE_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [ELAPSED_W-1:0] MS_MAX  = {ELAPSED_W{1'b1}};
  localparam logic ENABLE_OFF = 1'b0;
  localparam logic ENABLE_ON  = 1'b1;

  typedef struct {
    logic      enable;
    in_item_t  tick;
    bit        typed;
    out_item_t result;
  } tick_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  transfer_rate_weighted_window_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // predictor state
  logic               meter_enable = ENABLE_OFF;
  logic [TOTAL_W-1:0] last_total   = '0;
  logic [RATE_W-1:0]  rate_hist [WINDOW_DEPTH];
  int                 hist_fill    = 0;
  int                 hist_newest  = 0;

  out_item_t          expected_rates[$];
  tick_row_t          tick_table[$];
  int                 mismatches   = 0;
  int                 stall_left   = 0;
  int                 idle_cycles  = 0;
  bit                 sender_calm  = 1'b0;
  bit                 receiver_calm = 1'b0;
  logic [TOTAL_W-1:0] feed_total   = '0;
  logic               cur_enable;
  bit                 enable_known = 1'b0;

  function automatic bit rate_meter_step(input in_item_t tick, output out_item_t res);
    logic [TOTAL_W-1:0] delta;
    logic [63:0]        scaled;
    logic [63:0]        rate64;
    logic [RATE_W-1:0]  rate;
    logic [63:0]        wsum;
    logic [63:0]        wdiv;
    logic [63:0]        weight;
    int                 idx;
    res = '0;
    if (meter_enable == ENABLE_OFF || tick.elapsed_ms == '0) return 1'b0;
    delta = (tick.total_bytes > last_total) ? tick.total_bytes - last_total : '0;
    last_total = tick.total_bytes;
    scaled = {16'b0, delta} * 64'd1000;
    rate64 = scaled / {48'b0, tick.elapsed_ms};
    rate   = (rate64 > {24'b0, RATE_MAX}) ? RATE_MAX : rate64[RATE_W-1:0];
    hist_newest = (hist_newest + 1) % WINDOW_DEPTH;
    rate_hist[hist_newest] = rate;
    if (hist_fill < WINDOW_DEPTH) hist_fill++;
    wsum = '0;
    wdiv = '0;
    for (int k = 0; k < hist_fill; k++) begin
      weight = 64'(hist_fill - k);
      idx    = (hist_newest + WINDOW_DEPTH - k) % WINDOW_DEPTH;
      wsum  += {24'b0, rate_hist[idx]} * weight;
      wdiv  += weight;
    end
    res.average_rate = RATE_W'(wsum / wdiv);
    res.instant_rate = rate;
    res.samples_held = HELD_W'(hist_fill);
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTS) $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  // random gap length, with stretches of back-to-back traffic
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 63) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // drives one tick; typed rows replace the predicted result with a fixed one
  task automatic send_tick(input in_item_t tick, input bit typed, input out_item_t fixed);
    int        gap;
    out_item_t res;
    gap = draw_wait(sender_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= tick;
    do @(posedge clk); while (in_stall);
    if (rate_meter_step(tick, res)) expected_rates.push_back(typed ? fixed : res);
  endtask

  // enable is only rewritten once the core has gone quiet
  task automatic set_enable(input logic value);
    in_valid <= 1'b0;
    while (expected_rates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    meter_enable  = value;
    cur_enable    = value;
    enable_known  = 1'b1;
  endtask

  function automatic void add_row(input logic en, input logic [TOTAL_W-1:0] total,
                                  input logic [ELAPSED_W-1:0] ms, input bit typed,
                                  input logic [RATE_W-1:0] avg,
                                  input logic [RATE_W-1:0] inst,
                                  input logic [HELD_W-1:0] held);
    tick_row_t row;
    row.enable            = en;
    row.tick.total_bytes  = total;
    row.tick.elapsed_ms   = ms;
    row.typed             = typed;
    row.result.average_rate = avg;
    row.result.instant_rate = inst;
    row.result.samples_held = held;
    tick_table.push_back(row);
  endfunction

  function automatic in_item_t random_tick();
    in_item_t    tick;
    logic [63:0] r;
    int          kind;
    kind = $urandom_range(0, 99);
    r    = {$urandom(), $urandom()};
    if (kind < 70) begin
      // steady transfer: count moves forward by a delta of random size
      r = r >> $urandom_range(16, 63);
      tick.total_bytes = feed_total + r[TOTAL_W-1:0];
      tick.elapsed_ms  = ($urandom_range(0, 4) != 0) ? ELAPSED_W'($urandom_range(50, 200))
                                                      : ELAPSED_W'($urandom_range(1, 65535));
    end else if (kind < 80) begin
      tick.total_bytes = feed_total + r[19:0];
      tick.elapsed_ms  = '0;
    end else if (kind < 90) begin
      // count going backwards
      tick.total_bytes = feed_total - TOTAL_W'({16'b0, r[TOTAL_W-1:0]}
                                               % ({16'b0, feed_total} + 64'd1));
      tick.elapsed_ms  = ELAPSED_W'($urandom_range(1, 65535));
    end else begin
      tick.total_bytes = r[TOTAL_W-1:0];
      tick.elapsed_ms  = ELAPSED_W'($urandom_range(0, 65535));
    end
    if (tick.elapsed_ms != '0) feed_total = tick.total_bytes;
    return tick;
  endfunction

  // result side: scoreboard compare plus random stall per transaction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (out_valid && !out_stall) begin
      if (expected_rates.size() == 0) begin
        report_mismatch($sformatf("unexpected result avg %0d inst %0d held %0d",
                                  out_data.average_rate, out_data.instant_rate,
                                  out_data.samples_held));
      end else begin
        want = expected_rates.pop_front();
        if (out_data.average_rate !== want.average_rate)
          report_mismatch($sformatf("average_rate got %0d want %0d",
                                    out_data.average_rate, want.average_rate));
        if (out_data.instant_rate !== want.instant_rate)
          report_mismatch($sformatf("instant_rate got %0d want %0d",
                                    out_data.instant_rate, want.instant_rate));
        if (out_data.samples_held !== want.samples_held)
          report_mismatch($sformatf("samples_held got %0d want %0d",
                                    out_data.samples_held, want.samples_held));
      end
      stall_left = draw_wait(receiver_calm);
      out_stall <= (stall_left != 0);
    end else if (out_valid && out_stall) begin
      if (stall_left <= 1) out_stall <= 1'b0;
      stall_left = stall_left - 1;
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", IDLE_LIMIT);
      $display("** transfer_rate_weighted_window_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int        sent;
    int        phase_len;
    logic      phase_en;
    in_item_t  tick;
    out_item_t none;
    none = '0;
    sent = 0;

    // disabled ticks leave the stored total alone, so the first live tick measures from 0
    add_row(ENABLE_OFF, 48'h1234_5678_9ABC, 16'd100, 1'b0, '0, '0, '0);
    add_row(ENABLE_OFF, TOTAL_MAX, MS_MAX, 1'b0, '0, '0, '0);
    add_row(ENABLE_ON, 48'd0, 16'd1, 1'b1, 40'd0, 40'd0, 5'd1);
    add_row(ENABLE_ON, 48'd0, 16'd0, 1'b0, '0, '0, '0);
    add_row(ENABLE_ON, 48'd1000, 16'd1000, 1'b1, 40'd666, 40'd1000, 5'd2);
    add_row(ENABLE_ON, 48'd500, MS_MAX, 1'b1, 40'd333, 40'd0, 5'd3);
    // zero elapsed must not move the stored total
    add_row(ENABLE_ON, TOTAL_MAX, 16'd0, 1'b0, '0, '0, '0);
    add_row(ENABLE_ON, 48'd1500, 16'd1, 1'b1, 40'd400200, 40'd1000000, 5'd4);
    add_row(ENABLE_ON, TOTAL_MAX, 16'd1, 1'b0, '0, '0, '0);
    add_row(ENABLE_ON, TOTAL_MAX, MS_MAX, 1'b0, '0, '0, '0);
    add_row(ENABLE_ON, 48'd0, MS_MAX, 1'b0, '0, '0, '0);
    add_row(ENABLE_ON, TOTAL_MAX, MS_MAX, 1'b0, '0, '0, '0);
    add_row(ENABLE_OFF, 48'd5000, 16'd100, 1'b0, '0, '0, '0);
    add_row(ENABLE_ON, 48'd5000, 16'd100, 1'b0, '0, '0, '0);
    add_row(ENABLE_ON, 48'd5000 + 48'd123456, 16'd100, 1'b0, '0, '0, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (tick_table[i]) begin
      if (!enable_known || tick_table[i].enable != cur_enable)
        set_enable(tick_table[i].enable);
      send_tick(tick_table[i].tick, tick_table[i].typed, tick_table[i].result);
      sent++;
    end
    feed_total = last_total;

    while (sent < ITEM_TARGET) begin
      phase_en  = ($urandom_range(0, 3) != 0) ? ENABLE_ON : ENABLE_OFF;
      phase_len = $urandom_range(20, 120);
      if (phase_en != cur_enable) set_enable(phase_en);
      repeat (phase_len) begin
        tick = random_tick();
        send_tick(tick, 1'b0, none);
        sent++;
      end
    end

    in_valid <= 1'b0;
    while (expected_rates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** transfer_rate_weighted_window_core: PASSED **");
    end else begin
      $display("** transfer_rate_weighted_window_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/trww_pkg.sv
hdl/trww_divider.sv
hdl/transfer_rate_weighted_window_core.sv
bench/transfer_rate_weighted_window_core_test.sv
